FILE: hdl/assert_macros.svh
// assertion macros shared by the converter modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clk edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error(msg);

// condition that must never be seen outside reset
`define ASSERT_NEVER(lbl, expr, msg) \
  `ASSERT_CLK(lbl, !(expr), msg)

`endif

FILE: hdl/s2l_pkg.sv
// constants, tables and types of the gregorian to lunar date converter
`timescale 1ns / 1ps
`default_nettype none

package s2l_pkg;

  localparam int unsigned YEAR_COUNT = 201;
  localparam int unsigned IDX_W      = 8;
  localparam int unsigned WORD_W     = 17;
  localparam int unsigned DOY_W      = 9;
  localparam int unsigned DIFF_W     = 10;

  localparam logic [11:0] FIRST_YEAR = 12'd1900;
  localparam logic [11:0] LAST_YEAR  = 12'd2100;

  localparam logic [3:0] FIRST_MONTH     = 4'd1;
  localparam logic [3:0] MONTHS_PER_YEAR = 4'd12;
  localparam logic [4:0] LEAP_LEN_BIT    = 5'd16;
  localparam logic [4:0] SHORT_MONTH     = 5'd29;
  localparam logic [4:0] LONG_MONTH      = 5'd30;
  localparam logic [4:0] FEB_CUTOFF      = 5'd20;
  localparam logic [8:0] JAN_DAYS        = 9'd31;

  localparam logic [DIFF_W-1:0] YEAR_DAYS      = 10'd365;
  localparam logic [DIFF_W-1:0] LEAP_YEAR_DAYS = 10'd366;

  // month-length word per lunar year
  localparam logic [WORD_W-1:0] MONTH_WORDS [YEAR_COUNT] = '{
    17'h04bd8, 17'h04ae0, 17'h0a570, 17'h054d5, 17'h0d260, 17'h0d950, 17'h16554, 17'h056a0,
    17'h09ad0, 17'h055d2, 17'h04ae0, 17'h0a5b6, 17'h0a4d0, 17'h0d250, 17'h1d255, 17'h0b540,
    17'h0d6a0, 17'h0ada2, 17'h095b0, 17'h14977, 17'h04970, 17'h0a4b0, 17'h0b4b5, 17'h06a50,
    17'h06d40, 17'h1ab54, 17'h02b60, 17'h09570, 17'h052f2, 17'h04970, 17'h06566, 17'h0d4a0,
    17'h0ea50, 17'h16a95, 17'h05ad0, 17'h02b60, 17'h186e3, 17'h092e0, 17'h1c8d7, 17'h0c950,
    17'h0d4a0, 17'h1d8a6, 17'h0b550, 17'h056a0, 17'h1a5b4, 17'h025d0, 17'h092d0, 17'h0d2b2,
    17'h0a950, 17'h0b557, 17'h06ca0, 17'h0b550, 17'h15355, 17'h04da0, 17'h0a5b0, 17'h14573,
    17'h052b0, 17'h0a9a8, 17'h0e950, 17'h06aa0, 17'h0aea6, 17'h0ab50, 17'h04b60, 17'h0aae4,
    17'h0a570, 17'h05260, 17'h0f263, 17'h0d950, 17'h05b57, 17'h056a0, 17'h096d0, 17'h04dd5,
    17'h04ad0, 17'h0a4d0, 17'h0d4d4, 17'h0d250, 17'h0d558, 17'h0b540, 17'h0b6a0, 17'h195a6,
    17'h095b0, 17'h049b0, 17'h0a974, 17'h0a4b0, 17'h0b27a, 17'h06a50, 17'h06d40, 17'h0af46,
    17'h0ab60, 17'h09570, 17'h04af5, 17'h04970, 17'h064b0, 17'h074a3, 17'h0ea50, 17'h06b58,
    17'h05ac0, 17'h0ab60, 17'h096d5, 17'h092e0, 17'h0c960, 17'h0d954, 17'h0d4a0, 17'h0da50,
    17'h07552, 17'h056a0, 17'h0abb7, 17'h025d0, 17'h092d0, 17'h0cab5, 17'h0a950, 17'h0b4a0,
    17'h0baa4, 17'h0ad50, 17'h055d9, 17'h04ba0, 17'h0a5b0, 17'h15176, 17'h052b0, 17'h0a930,
    17'h07954, 17'h06aa0, 17'h0ad50, 17'h05b52, 17'h04b60, 17'h0a6e6, 17'h0a4e0, 17'h0d260,
    17'h0ea65, 17'h0d530, 17'h05aa0, 17'h076a3, 17'h096d0, 17'h04afb, 17'h04ad0, 17'h0a4d0,
    17'h1d0b6, 17'h0d250, 17'h0d520, 17'h0dd45, 17'h0b5a0, 17'h056d0, 17'h055b2, 17'h049b0,
    17'h0a577, 17'h0a4b0, 17'h0aa50, 17'h1b255, 17'h06d20, 17'h0ada0, 17'h14b63, 17'h09370,
    17'h049f8, 17'h04970, 17'h064b0, 17'h168a6, 17'h0ea50, 17'h06aa0, 17'h1a6c4, 17'h0aae0,
    17'h092e0, 17'h0d2e3, 17'h0c960, 17'h0d557, 17'h0d4a0, 17'h0da50, 17'h05d55, 17'h056a0,
    17'h0a6d0, 17'h055d4, 17'h052d0, 17'h0a9b8, 17'h0a950, 17'h0b4a0, 17'h0b6a6, 17'h0ad50,
    17'h055a0, 17'h0aba4, 17'h0a5b0, 17'h052b0, 17'h0b273, 17'h06930, 17'h07337, 17'h06aa0,
    17'h0ad50, 17'h14b55, 17'h04b60, 17'h0a570, 17'h054e4, 17'h0d160, 17'h0e968, 17'h0d520,
    17'h0daa0, 17'h16aa6, 17'h056d0, 17'h04ae0, 17'h0a9d4, 17'h0a4d0, 17'h0d150, 17'h0f252,
    17'h0d520
  };

  // new year day: january when above the cutoff, else february
  localparam logic [4:0] NEW_YEAR_DAY [YEAR_COUNT] = '{
    5'd31, 5'd19, 5'd8,  5'd29, 5'd16, 5'd4,  5'd25, 5'd13, 5'd2,  5'd22,
    5'd10, 5'd30, 5'd18, 5'd6,  5'd26, 5'd14, 5'd3,  5'd23, 5'd11, 5'd28,
    5'd17, 5'd8,  5'd28, 5'd16, 5'd5,  5'd25, 5'd13, 5'd2,  5'd23, 5'd10,
    5'd30, 5'd17, 5'd7,  5'd26, 5'd15, 5'd4,  5'd24, 5'd11, 5'd31, 5'd19,
    5'd8,  5'd27, 5'd15, 5'd5,  5'd25, 5'd13, 5'd2,  5'd22, 5'd10, 5'd29,
    5'd17, 5'd6,  5'd27, 5'd15, 5'd3,  5'd24, 5'd12, 5'd31, 5'd18, 5'd8,
    5'd28, 5'd15, 5'd5,  5'd25, 5'd13, 5'd2,  5'd21, 5'd9,  5'd30, 5'd17,
    5'd6,  5'd27, 5'd15, 5'd3,  5'd23, 5'd11, 5'd31, 5'd18, 5'd7,  5'd28,
    5'd16, 5'd5,  5'd25, 5'd13, 5'd2,  5'd20, 5'd9,  5'd29, 5'd17, 5'd6,
    5'd27, 5'd15, 5'd4,  5'd23, 5'd10, 5'd31, 5'd19, 5'd7,  5'd28, 5'd16,
    5'd5,  5'd24, 5'd12, 5'd1,  5'd22, 5'd10, 5'd29, 5'd18, 5'd7,  5'd26,
    5'd14, 5'd3,  5'd23, 5'd10, 5'd31, 5'd19, 5'd8,  5'd28, 5'd16, 5'd5,
    5'd25, 5'd12, 5'd1,  5'd22, 5'd10, 5'd29, 5'd17, 5'd6,  5'd26, 5'd13,
    5'd3,  5'd23, 5'd11, 5'd31, 5'd19, 5'd8,  5'd28, 5'd15, 5'd5,  5'd24,
    5'd12, 5'd1,  5'd21, 5'd10, 5'd29, 5'd18, 5'd7,  5'd26, 5'd14, 5'd3,
    5'd22, 5'd10, 5'd30, 5'd18, 5'd6,  5'd26, 5'd15, 5'd4,  5'd23, 5'd11,
    5'd29, 5'd19, 5'd7,  5'd27, 5'd16, 5'd5,  5'd24, 5'd12, 5'd1,  5'd22,
    5'd9,  5'd29, 5'd18, 5'd6,  5'd26, 5'd13, 5'd3,  5'd22, 5'd11, 5'd30,
    5'd18, 5'd7,  5'd26, 5'd14, 5'd3,  5'd24, 5'd12, 5'd1,  5'd20, 5'd9,
    5'd29, 5'd17, 5'd7,  5'd26, 5'd14, 5'd3,  5'd23, 5'd10, 5'd31, 5'd19,
    5'd8
  };

  localparam logic [DOY_W-1:0] DAYS_BEFORE_MONTH [13] = '{
    9'd0, 9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181, 9'd212, 9'd243,
    9'd273, 9'd304, 9'd334
  };

  // result of the month walk
  typedef struct packed {
    logic       done;
    logic [3:0] month;
    logic [4:0] day;
    logic       leap;
  } walk_res_t;

  // gregorian leap rule, valid for years 1899 to 2100
  function automatic logic is_leap(input logic [11:0] y);
    return (y[1:0] == 2'b00) && (y != FIRST_YEAR) && (y != LAST_YEAR);
  endfunction

  // day of year of a lunar new year
  function automatic logic [DOY_W-1:0] new_year_doy(input logic [4:0] v);
    return (v <= FEB_CUTOFF) ? (JAN_DAYS + {4'd0, v}) : {4'd0, v};
  endfunction

endpackage

`default_nettype wire

FILE: hdl/s2l_if.sv
// valid/ready channels for solar date words and lunar date words
`timescale 1ns / 1ps
`default_nettype none

interface s2l_in_if;
  logic        valid;
  logic        ready;
  logic [11:0] solar_year;
  logic [3:0]  solar_month;
  logic [4:0]  solar_day;

  modport source (output valid, output solar_year, output solar_month,
                  output solar_day, input ready);
  modport sink (input valid, input solar_year, input solar_month,
                input solar_day, output ready);
endinterface

interface s2l_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] lunar_year;
  logic [3:0]  lunar_month;
  logic [4:0]  lunar_day;
  logic        leap_month;
  logic        in_range;

  modport source (output valid, output lunar_year, output lunar_month,
                  output lunar_day, output leap_month, output in_range, input ready);
  modport sink (input valid, input lunar_year, input lunar_month,
                input lunar_day, input leap_month, input in_range, output ready);
endinterface

`default_nettype wire

FILE: hdl/s2l_walk.sv
// month walk: one shared compare and subtract step per lunar month
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module s2l_walk
  import s2l_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [WORD_W-1:0] word,
  input  logic [DIFF_W-1:0] diff,
  output walk_res_t         res
);

  logic              busy;
  logic [3:0]        month;
  logic              in_leap;
  logic [DIFF_W-1:0] rest;
  logic [WORD_W-1:0] word_r;

  logic [4:0]        bit_sel;
  logic [4:0]        len;
  logic              fits;
  logic              enter_leap;
  logic              last;
  logic [DIFF_W-1:0] rest_sub;
  logic [4:0]        day_sat;

  always_comb begin
    bit_sel    = LEAP_LEN_BIT - {1'b0, month};
    len        = (in_leap ? word_r[LEAP_LEN_BIT] : word_r[bit_sel]) ? LONG_MONTH : SHORT_MONTH;
    fits       = rest < {{(DIFF_W-5){1'b0}}, len};
    rest_sub   = rest - {{(DIFF_W-5){1'b0}}, len};
    enter_leap = !in_leap && (month == word_r[3:0]);
    last       = !fits && (month == MONTHS_PER_YEAR) && !enter_leap;
    day_sat    = (rest_sub >= {{(DIFF_W-5){1'b0}}, LONG_MONTH}) ? LONG_MONTH
               : 5'(rest_sub + {{(DIFF_W-1){1'b0}}, 1'b1});
    res.done   = busy && (fits || last);
    res.month  = fits ? month : MONTHS_PER_YEAR;
    res.day    = fits ? 5'(rest + {{(DIFF_W-1){1'b0}}, 1'b1}) : day_sat;
    res.leap   = fits && in_leap;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (res.done) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      month   <= FIRST_MONTH;
      in_leap <= 1'b0;
      rest    <= diff;
      word_r  <= word;
    end else if (busy && !res.done) begin
      rest <= rest_sub;
      if (enter_leap) begin
        in_leap <= 1'b1;
      end else begin
        in_leap <= 1'b0;
        month   <= 4'(month + 4'd1);
      end
    end
  end

  `ASSERT_CLK(a_month_range, busy |-> (month >= FIRST_MONTH && month <= MONTHS_PER_YEAR),
              "walk month out of range")
  `ASSERT_CLK(a_leap_matches, (busy && in_leap) |-> (month == word_r[3:0]),
              "leap step on a month that has no leap")
  `ASSERT_CLK(a_done_ends, (res.done && !start) |=> !busy, "walk kept running after done")
  `ASSERT_CLK(a_day_range, res.done |-> (res.day >= 5'd1 && res.day <= LONG_MONTH),
              "lunar day out of range")

endmodule

`default_nettype wire

FILE: hdl/solar_to_lunar_date_converter.sv
// top level: gregorian date to chinese lunar date, years 1900 to 2100
//
//  channel  dir  word                                                     handshake
//  in_ch    in   solar_year, solar_month, solar_day                       valid/ready
//  out_ch   out  lunar_year, lunar_month, lunar_day, leap_month, in_range valid/ready
//
// an accepted word passes through prep, offset, an extra step when the date falls
// before this year's new year, word load, then the month walk at one month or leap
// month per cycle (up to 13 months), then the output load. out-of-range dates go
// from prep or offset straight to the output load. one word is in flight at a time.
// the output register lets the next word be taken while a result waits.
// reset is synchronous and clears control state only.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module solar_to_lunar_date_converter
  import s2l_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  s2l_in_if.sink    in_ch,
  s2l_out_if.source out_ch
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_PREP = 7'b0000010,
    S_OFFS = 7'b0000100,
    S_BACK = 7'b0001000,
    S_LOAD = 7'b0010000,
    S_WALK = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  state_t state;

  logic [11:0]       y_r;
  logic [3:0]        mo_r;
  logic [4:0]        d_r;
  logic [IDX_W-1:0]  idx;
  logic [DOY_W-1:0]  doy;
  logic [DIFF_W-1:0] diff;
  logic [11:0]       ly;

  logic [11:0] res_year;
  logic [3:0]  res_month;
  logic [4:0]  res_day;
  logic        res_leap;
  logic        res_ok;

  logic        out_valid;
  logic [11:0] out_year;
  logic [3:0]  out_month;
  logic [4:0]  out_day;
  logic        out_leap;
  logic        out_ok;

  logic              accept;
  logic              year_ok;
  logic [3:0]        mo_c;
  logic [DOY_W-1:0]  doy_c;
  logic [DOY_W-1:0]  ny;
  logic [11:0]       y_prev;
  logic              walk_start;
  logic [WORD_W-1:0] walk_word;
  walk_res_t         wres;
  logic              load_out;

  assign accept   = in_ch.valid && in_ch.ready;
  assign load_out = (state == S_DONE) && (!out_valid || out_ch.ready);

  always_comb begin
    year_ok = (y_r >= FIRST_YEAR) && (y_r <= LAST_YEAR);
    if (mo_r == 4'd0) begin
      mo_c = FIRST_MONTH;
    end else if (mo_r > MONTHS_PER_YEAR) begin
      mo_c = MONTHS_PER_YEAR;
    end else begin
      mo_c = mo_r;
    end
    doy_c = DAYS_BEFORE_MONTH[mo_c] + {4'd0, d_r}
          + {{(DOY_W-1){1'b0}}, (mo_c > 4'd2) && is_leap(y_r)};
    ny         = new_year_doy(NEW_YEAR_DAY[idx]);
    y_prev     = 12'(y_r - 12'd1);
    walk_start = (state == S_LOAD);
    walk_word  = MONTH_WORDS[idx];
  end

  s2l_walk u_walk (
    .clk   (clk),
    .rst   (rst),
    .start (walk_start),
    .word  (walk_word),
    .diff  (diff),
    .res   (wres)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) state <= S_PREP;
        end
        S_PREP: begin
          state <= year_ok ? S_OFFS : S_DONE;
        end
        S_OFFS: begin
          if (doy >= ny) begin
            state <= S_LOAD;
          end else if (idx == '0) begin
            state <= S_DONE;
          end else begin
            state <= S_BACK;
          end
        end
        S_BACK: state <= S_LOAD;
        S_LOAD: state <= S_WALK;
        S_WALK: begin
          if (wres.done) state <= S_DONE;
        end
        S_DONE: begin
          if (load_out) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      y_r  <= in_ch.solar_year;
      mo_r <= in_ch.solar_month;
      d_r  <= in_ch.solar_day;
    end
    case (state)
      S_PREP: begin
        doy       <= doy_c;
        idx       <= IDX_W'(y_r - FIRST_YEAR);
        res_year  <= '0;
        res_month <= '0;
        res_day   <= '0;
        res_leap  <= 1'b0;
        res_ok    <= 1'b0;
      end
      S_OFFS: begin
        if (doy >= ny) begin
          diff <= {1'b0, doy} - {1'b0, ny};
          ly   <= y_r;
        end else begin
          diff <= {1'b0, doy} + (is_leap(y_prev) ? LEAP_YEAR_DAYS : YEAR_DAYS);
          ly   <= y_prev;
          idx  <= IDX_W'(idx - 1'b1);
        end
      end
      S_BACK: begin
        diff <= diff - {1'b0, ny};
      end
      S_WALK: begin
        if (wres.done) begin
          res_year  <= ly;
          res_month <= wres.month;
          res_day   <= wres.day;
          res_leap  <= wres.leap;
          res_ok    <= 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_year  <= res_year;
      out_month <= res_month;
      out_day   <= res_day;
      out_leap  <= res_leap;
      out_ok    <= res_ok;
    end
  end

  assign in_ch.ready        = (state == S_IDLE);
  assign out_ch.valid       = out_valid;
  assign out_ch.lunar_year  = out_year;
  assign out_ch.lunar_month = out_month;
  assign out_ch.lunar_day   = out_day;
  assign out_ch.leap_month  = out_leap;
  assign out_ch.in_range    = out_ok;

  `ASSERT_CLK(a_state_onehot, $onehot(state), "state register not one-hot")
  `ASSERT_CLK(a_accept_prep, accept |=> (state == S_PREP), "accepted word did not start")
  `ASSERT_CLK(a_zero_when_out, (out_valid && !out_ok) |->
              (out_year == 12'd0 && out_month == 4'd0 && out_day == 5'd0 && !out_leap),
              "out-of-range result carries nonzero fields")

endmodule

`default_nettype wire

FILE: test/testbench.sv
// testbench for the gregorian to lunar date converter: predicted results checked word by word
`timescale 1ns / 1ps

import s2l_pkg::*;

typedef struct packed {
  logic [11:0] year;
  logic [3:0]  month;
  logic [4:0]  day;
  logic        leap;
  logic        ok;
} lunar_date_t;

typedef struct packed {
  logic [11:0] year;
  logic [3:0]  month;
  logic [4:0]  day;
} solar_date_t;

typedef struct packed {
  solar_date_t solar;
  lunar_date_t lunar;
} date_pair_t;

function automatic bit greg_leap(int unsigned y);
  return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
endfunction

class lunar_scoreboard;
  date_pair_t lunar_due[$];
  int         failures;

  function new();
    failures = 0;
  endfunction

  // day of year of the lunar new year at table index idx
  function int unsigned new_year_of(int unsigned idx);
    int unsigned v;
    v = NEW_YEAR_DAY[idx];
    return (v <= 20) ? 31 + v : v;
  endfunction

  function lunar_date_t convert_date(solar_date_t s);
    lunar_date_t r;
    int unsigned idx, mon, doy, ny, diff, mm, len;
    logic [16:0] word;
    int unsigned leap_at;
    r = '0;
    if (s.year < FIRST_YEAR || s.year > LAST_YEAR) return r;
    idx = s.year - 1900;
    mon = s.month;
    if (mon == 0) mon = 1;
    if (mon > 12) mon = 12;
    doy = DAYS_BEFORE_MONTH[mon] + s.day;
    if (mon > 2 && greg_leap(s.year)) doy++;
    ny = new_year_of(idx);
    if (doy >= ny) begin
      diff = doy - ny;
      r.year = s.year;
    end else begin
      if (idx == 0) return r;
      diff = doy + (greg_leap(s.year - 1) ? 366 : 365) - new_year_of(idx - 1);
      r.year = s.year - 12'd1;
      idx--;
    end
    word = MONTH_WORDS[idx];
    leap_at = word[3:0];
    r.ok = 1'b1;
    for (mm = 1; mm <= 12; mm++) begin
      len = word[16 - mm] ? 30 : 29;
      if (diff < len) begin
        r.month = 4'(mm);
        r.day = 5'(diff + 1);
        return r;
      end
      diff -= len;
      if (mm == leap_at) begin
        len = word[16] ? 30 : 29;
        if (diff < len) begin
          r.month = 4'(mm);
          r.day = 5'(diff + 1);
          r.leap = 1'b1;
          return r;
        end
        diff -= len;
      end
    end
    r.month = 4'd12;
    r.day = (diff + 1 > 30) ? 5'd30 : 5'(diff + 1);
    return r;
  endfunction

  function void note_date(solar_date_t s);
    date_pair_t p;
    p.solar = s;
    p.lunar = convert_date(s);
    lunar_due.push_back(p);
  endfunction

  function void check_lunar(lunar_date_t got);
    date_pair_t p;
    if (lunar_due.size() == 0) begin
      failures++;
      if (failures <= 10)
        $display("unexpected result: %0d/%0d/%0d leap %0d ok %0d",
                 got.year, got.month, got.day, got.leap, got.ok);
      return;
    end
    p = lunar_due.pop_front();
    if (got !== p.lunar) begin
      failures++;
      if (failures <= 10)
        $display({"mismatch for %0d-%0d-%0d: expected %0d/%0d/%0d leap %0d ok %0d, ",
                  "got %0d/%0d/%0d leap %0d ok %0d"},
                 p.solar.year, p.solar.month, p.solar.day,
                 p.lunar.year, p.lunar.month, p.lunar.day, p.lunar.leap, p.lunar.ok,
                 got.year, got.month, got.day, got.leap, got.ok);
    end
  endfunction

  function int pending();
    return lunar_due.size();
  endfunction
endclass

module testbench;
  localparam int IDLE_LIMIT   = 2000;
  localparam int RANDOM_DATES = 1800;

  logic clk;
  logic rst;
  int   idle_cycles;
  int   send_burst;
  int   recv_burst;

  s2l_in_if  in_ch();
  s2l_out_if out_ch();

  lunar_scoreboard sb = new();

  solar_to_lunar_date_converter u_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic send_date(input logic [11:0] y, input logic [3:0] m, input logic [4:0] d);
    int gap;
    solar_date_t s;
    if (send_burst > 0) begin
      gap = 0;
      send_burst--;
    end else begin
      gap = $urandom_range(0, 12);
      if ($urandom_range(0, 15) == 0) send_burst = $urandom_range(10, 40);
    end
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.solar_year  <= y;
    in_ch.solar_month <= m;
    in_ch.solar_day   <= d;
    do @(posedge clk); while (!in_ch.ready);
    s.year  = y;
    s.month = m;
    s.day   = d;
    sb.note_date(s);
  endtask

  initial begin
    lunar_date_t got;
    int stall;
    do @(posedge clk); while (rst);
    forever begin
      if (recv_burst > 0) begin
        stall = 0;
        recv_burst--;
      end else begin
        stall = $urandom_range(0, 12);
        if ($urandom_range(0, 15) == 0) recv_burst = $urandom_range(10, 40);
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      got.year  = out_ch.lunar_year;
      got.month = out_ch.lunar_month;
      got.day   = out_ch.lunar_day;
      got.leap  = out_ch.leap_month;
      got.ok    = out_ch.in_range;
      sb.check_lunar(got);
    end
  end

  initial begin
    int kind;
    int mdays;
    logic [11:0] y;
    logic [3:0]  m;
    logic [4:0]  d;
    rst               <= 1'b1;
    in_ch.valid       <= 1'b0;
    in_ch.solar_year  <= '0;
    in_ch.solar_month <= '0;
    in_ch.solar_day   <= '0;
    out_ch.ready      <= 1'b0;
    send_burst        = 0;
    recv_burst        = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // table edges, out of range years, odd months and days, leap months
    send_date(12'd1900, 4'd1, 5'd30);
    send_date(12'd1900, 4'd1, 5'd31);
    send_date(12'd1899, 4'd12, 5'd31);
    send_date(12'd2101, 4'd1, 5'd1);
    send_date(12'd0, 4'd0, 5'd0);
    send_date(12'd4095, 4'd15, 5'd31);
    send_date(12'd2100, 4'd12, 5'd31);
    send_date(12'd2100, 4'd1, 5'd1);
    send_date(12'd2100, 4'd2, 5'd9);
    send_date(12'd1900, 4'd0, 5'd31);
    send_date(12'd2024, 4'd15, 5'd31);
    send_date(12'd2024, 4'd13, 5'd1);
    send_date(12'd2023, 4'd2, 5'd30);
    send_date(12'd2023, 4'd3, 5'd0);
    send_date(12'd2000, 4'd2, 5'd29);
    send_date(12'd2000, 4'd3, 5'd1);
    send_date(12'd1900, 4'd3, 5'd1);
    send_date(12'd2023, 4'd3, 5'd25);
    send_date(12'd2023, 4'd4, 5'd20);
    send_date(12'd2020, 4'd5, 5'd30);
    send_date(12'd2033, 4'd12, 5'd25);
    send_date(12'd1901, 4'd2, 5'd18);
    send_date(12'd2099, 4'd1, 5'd20);

    for (int i = 0; i < RANDOM_DATES; i++) begin
      kind = $urandom_range(0, 99);
      y = 12'($urandom_range(1900, 2100));
      if (kind < 65) begin
        m = 4'($urandom_range(1, 12));
        case (m)
          4'd2:                      mdays = greg_leap(y) ? 29 : 28;
          4'd4, 4'd6, 4'd9, 4'd11:   mdays = 30;
          default:                   mdays = 31;
        endcase
        d = 5'($urandom_range(1, mdays));
      end else if (kind < 80) begin
        // around the lunar new year
        m = 4'($urandom_range(1, 2));
        d = 5'($urandom_range(1, (m == 4'd1) ? 31 : 28));
      end else if (kind < 92) begin
        m = 4'($urandom_range(0, 15));
        d = 5'($urandom_range(0, 31));
      end else begin
        y = 12'($urandom_range(0, 4095));
        m = 4'($urandom_range(0, 15));
        d = 5'($urandom_range(0, 31));
      end
      send_date(y, m, d);
    end
    in_ch.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
